// ===== sv/glc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glc_pkg: shared types and constants for the grid locator converter
// Word layouts, error codes, register indexes and the QRA offset tables.
// ----------------------------------------------------------------------------
package glc_pkg;

  // field widths
  localparam int LonW  = 21;
  localparam int LatW  = 20;
  localparam int CalcW = 23;
  localparam int CntW  = 4;

  // wrap periods in arc-seconds (26 big squares)
  localparam int LonPeriod = 26 * 7200;
  localparam int LatPeriod = 26 * 3600;
  localparam int LonHalf   = LonPeriod / 2;
  localparam int LatHalf   = LatPeriod / 2;
  localparam int MaxWraps  = 8;

  // register reset values
  localparam int RefLonReset = -32008;
  localparam int RefLatReset = 175113;

  // ascii codes
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChJ     = 8'h4A;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch8     = 8'h38;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CHAR   = 2'd1,
    ERR_SQUARE = 2'd2
  } err_t;

  typedef enum logic {
    REG_REF_LON = 1'b0,
    REG_REF_LAT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_MAIDENHEAD = 1'b0,
    KIND_QRA        = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [7:0] char4;
    logic [7:0] char5;
  } locator_t;

  typedef struct packed {
    logic signed [LonW-1:0] longitude_seconds;
    logic signed [LatW-1:0] latitude_seconds;
    err_t                   error_code;
  } result_t;

  // decoded characters after the first stage
  typedef struct packed {
    kind_t      kind;
    logic       err_char;
    logic [4:0] a0;
    logic [4:0] a1;
    logic [3:0] d2;
    logic [3:0] d3;
    logic [4:0] a4;
    logic [4:0] a5;
  } dec_t;

  // uncentered coordinates handed to the centering stages
  typedef struct packed {
    err_t                   err;
    logic                   center;
    logic signed [LonW-1:0] lon;
    logic signed [LatW-1:0] lat;
  } raw_t;

  // qra sub-square longitude offset
  function automatic logic [LonW-1:0] qra_lon_off(input logic [3:0] k);
    logic [LonW-1:0] v;
    case (k)
      4'd0:    v = LonW'(240);
      4'd1:    v = LonW'(480);
      4'd2:    v = LonW'(480);
      4'd3:    v = LonW'(480);
      4'd4:    v = LonW'(240);
      4'd9:    v = LonW'(240);
      default: v = '0;
    endcase
    return v;
  endfunction

  // qra sub-square latitude offset
  function automatic logic [LatW-1:0] qra_lat_off(input logic [3:0] k);
    logic [LatW-1:0] v;
    case (k)
      4'd0:    v = LatW'(300);
      4'd1:    v = LatW'(300);
      4'd2:    v = LatW'(150);
      4'd6:    v = LatW'(150);
      4'd7:    v = LatW'(300);
      4'd9:    v = LatW'(150);
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold lower case letters to upper case
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= ChLowA && c <= ChLowZ) u = c - CaseGap;
    return u;
  endfunction

endpackage

// ===== sv/glc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glc_decode: locator character decode and square coordinates
// Stage one folds case and range-checks every character the kind uses, stage two forms
// the uncentered square centre and the QRA square-number check.
// ----------------------------------------------------------------------------
module glc_decode
  import glc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  locator_t locator,
  output logic     raw_valid,
  output raw_t     raw
);

  logic       s1_valid;
  dec_t       s1;
  dec_t       s1_next;

  // stage one: fold case, check ranges, strip ascii offsets
  always_comb begin
    logic [7:0] u0, u1, u2, u3, u4, u5;
    logic       bad_m, bad_q;
    u0 = upcase(locator.char0);
    u1 = upcase(locator.char1);
    u2 = upcase(locator.char2);
    u3 = upcase(locator.char3);
    u4 = upcase(locator.char4);
    u5 = upcase(locator.char5);
    bad_m = !(u0 >= ChA && u0 <= ChR) || !(u1 >= ChA && u1 <= ChR) ||
            !(u2 >= Ch0 && u2 <= Ch9) || !(u3 >= Ch0 && u3 <= Ch9) ||
            !(u4 >= ChA && u4 <= ChX) || !(u5 >= ChA && u5 <= ChX);
    bad_q = !(u0 >= ChA && u0 <= ChZ) || !(u1 >= ChA && u1 <= ChZ) ||
            !(u2 >= Ch0 && u2 <= Ch8) || !(u3 >= Ch0 && u3 <= Ch9) ||
            !(u4 >= ChA && u4 <= ChJ) || (u4 == ChI);
    s1_next.kind     = kind_t'(locator.kind);
    s1_next.err_char = locator.kind ? bad_q : bad_m;
    s1_next.a0       = 5'(u0 - ChA);
    s1_next.a1       = 5'(u1 - ChA);
    s1_next.d2       = 4'(u2 - Ch0);
    s1_next.d3       = 4'(u3 - Ch0);
    s1_next.a4       = 5'(u4 - ChA);
    s1_next.a5       = 5'(u5 - ChA);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1 <= s1_next;
  end

  // stage two: square centre for both kinds, select by kind
  raw_t raw_next;

  always_comb begin
    logic [3:0]      qmod;
    logic [2:0]      qdiv;
    logic            bad_sq;
    logic [LonW-1:0] m_lon, q_lon;
    logic [LatW-1:0] m_lat, q_lat;
    // (z - 1) split into tens and units without a divider
    qmod   = (s1.d3 == 4'd0) ? 4'd9 : (s1.d3 - 4'd1);
    qdiv   = (s1.d3 == 4'd0) ? 3'(s1.d2 - 4'd1) : s1.d2[2:0];
    bad_sq = (s1.d2 == 4'd0 && s1.d3 == 4'd0) || (s1.d2 == 4'd8 && s1.d3 != 4'd0);
    m_lon = LonW'(648000) - LonW'(s1.a0) * LonW'(72000) - LonW'(s1.d2) * LonW'(7200)
          - LonW'(s1.a4) * LonW'(300) - LonW'(150);
    m_lat = LatW'(0) - LatW'(324000) + LatW'(s1.a1) * LatW'(36000)
          + LatW'(s1.d3) * LatW'(3600) + LatW'(s1.a5) * LatW'(150) + LatW'(75);
    q_lon = LonW'(0) - LonW'(s1.a0) * LonW'(7200) - LonW'(qmod) * LonW'(720)
          - qra_lon_off(s1.a4[3:0]) - LonW'(120);
    q_lat = LatW'(144000) + LatW'(s1.a1) * LatW'(3600)
          + LatW'(3'd7 - qdiv) * LatW'(450) + qra_lat_off(s1.a4[3:0]) + LatW'(75);
    if (s1.err_char) begin
      raw_next.err = ERR_CHAR;
    end else if (s1.kind == KIND_QRA && bad_sq) begin
      raw_next.err = ERR_SQUARE;
    end else begin
      raw_next.err = ERR_NONE;
    end
    raw_next.center = (s1.kind == KIND_QRA);
    raw_next.lon    = (s1.kind == KIND_QRA) ? q_lon : m_lon;
    raw_next.lat    = (s1.kind == KIND_QRA) ? q_lat : m_lat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else begin
      raw_valid <= s1_valid;
    end
    raw <= raw_next;
  end

endmodule

// ===== sv/grid_locator_to_coordinates_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_locator_to_coordinates_unit: locator string to square centre
// Five-stage pipeline: decode, square centre, distance to reference,
// period count, period correction and output register.
// ----------------------------------------------------------------------------
// an accepted word passes the decode, square centre, distance, period count and output
// registers in that order before result_valid rises
// throughput: one locator per cycle; the five register stages set the latency
// busy is high only while rst is high; the receiver cannot stall the results
// synchronous reset clears all pipeline valids and loads the reference
// registers with their reset position
module grid_locator_to_coordinates_unit
  import glc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  locator_t        locator,
  output logic            result_valid,
  output result_t         result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cfg_reg_t        cfg_index,
  input  logic [LonW-1:0] cfg_data
);

  logic signed [LonW-1:0] ref_lon;
  logic signed [LatW-1:0] ref_lat;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // reference position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_lon <= LonW'(RefLonReset);
      ref_lat <= LatW'(RefLatReset);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REF_LON: ref_lon <= cfg_data;
        REG_REF_LAT: ref_lat <= cfg_data[LatW-1:0];
        default: ;
      endcase
    end
  end

  // stages one and two
  logic raw_valid;
  raw_t raw;

  glc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .locator   (locator),
    .raw_valid (raw_valid),
    .raw       (raw)
  );

  // stage three: signed distance past each edge of the reference window
  logic                    s3_valid;
  raw_t                    s3;
  logic signed [CalcW-1:0] e_lon, f_lon, e_lat, f_lat;

  always_ff @(posedge clk) begin
    logic signed [CalcW-1:0] v_lon, c_lon, v_lat, c_lat;
    v_lon = CalcW'(raw.lon);
    c_lon = CalcW'(ref_lon);
    v_lat = CalcW'(raw.lat);
    c_lat = CalcW'(ref_lat);
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= raw_valid;
    end
    s3    <= raw;
    e_lon <= v_lon - c_lon - CalcW'(LonHalf);
    f_lon <= c_lon - CalcW'(LonHalf) - v_lon;
    e_lat <= v_lat - c_lat - CalcW'(LatHalf);
    f_lat <= c_lat - CalcW'(LatHalf) - v_lat;
  end

  // stage four: whole periods to move, as ceil(distance / period)
  logic            s4_valid;
  raw_t            s4;
  logic [CntW-1:0] dec_lon, inc_lon, dec_lat, inc_lat;
  logic [CntW-1:0] dec_lon_next, inc_lon_next, dec_lat_next, inc_lat_next;

  always_comb begin
    dec_lon_next = '0;
    inc_lon_next = '0;
    dec_lat_next = '0;
    inc_lat_next = '0;
    for (int k = 0; k < MaxWraps; k++) begin
      if (e_lon > $signed(CalcW'(k * LonPeriod))) dec_lon_next = dec_lon_next + 1'b1;
      if (f_lon > $signed(CalcW'(k * LonPeriod))) inc_lon_next = inc_lon_next + 1'b1;
      if (e_lat > $signed(CalcW'(k * LatPeriod))) dec_lat_next = dec_lat_next + 1'b1;
      if (f_lat > $signed(CalcW'(k * LatPeriod))) inc_lat_next = inc_lat_next + 1'b1;
    end
    // maidenhead results stay where they are
    if (!s3.center) begin
      dec_lon_next = '0;
      inc_lon_next = '0;
      dec_lat_next = '0;
      inc_lat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4      <= s3;
    dec_lon <= dec_lon_next;
    inc_lon <= inc_lon_next;
    dec_lat <= dec_lat_next;
    inc_lat <= inc_lat_next;
  end

  // stage five: apply the period correction, zero on error
  result_t result_next;

  always_comb begin
    logic [CalcW-1:0] lon_sum, lat_sum;
    lon_sum = CalcW'(s4.lon) - CalcW'(dec_lon) * CalcW'(LonPeriod)
            + CalcW'(inc_lon) * CalcW'(LonPeriod);
    lat_sum = CalcW'(s4.lat) - CalcW'(dec_lat) * CalcW'(LatPeriod)
            + CalcW'(inc_lat) * CalcW'(LatPeriod);
    result_next.error_code = s4.err;
    if (s4.err != ERR_NONE) begin
      result_next.longitude_seconds = '0;
      result_next.latitude_seconds  = '0;
    end else begin
      result_next.longitude_seconds = lon_sum[LonW-1:0];
      result_next.latitude_seconds  = lat_sum[LatW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s4_valid;
    end
    result <= result_next;
  end

`ifndef NO_ASSERTIONS
  // every accepted word comes out as a result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 result_valid)
    else $error("result strobe missing after accepted word");

  // no strobe without an accepted word behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    ##5 result_valid |-> $past(start && !busy, 5))
    else $error("result strobe without accepted word");

  // an error always carries zero coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error_code != ERR_NONE) |->
      (result.longitude_seconds == '0 && result.latitude_seconds == '0))
    else $error("error result with nonzero coordinates");

  // only one direction of period correction at a time
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> ((dec_lon == '0 || inc_lon == '0) && (dec_lat == '0 || inc_lat == '0)))
    else $error("period correction in both directions");
`endif

endmodule
